### sv/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

    localparam int PFS_ENTRIES = 256;

    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 8;
    localparam int COLOR_W  = 16;
    localparam int SEQ_W    = 3;
    localparam int DEPTH_W  = 9;
    localparam int MODE_W   = 8;
    localparam int DELAY_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [ACTION_W-1:0] ACT_LOAD     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UPDATE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_VANISH   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FADE_OUT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FADE_IN  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RESTORE  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd6;

    localparam logic [SEQ_W-1:0] SEQ_IDLE     = 3'd0;
    localparam logic [SEQ_W-1:0] SEQ_MARK     = 3'd1;
    localparam logic [SEQ_W-1:0] SEQ_FADE_OUT = 3'd2;
    localparam logic [SEQ_W-1:0] SEQ_VANISH   = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_FADE_IN  = 3'd4;
    localparam logic [SEQ_W-1:0] SEQ_RESTORE  = 3'd5;
    localparam logic [SEQ_W-1:0] SEQ_DEAD     = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_TRANS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLENDING    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RENDER_MODE = 2'd3;

    localparam logic [1:0] MARK_NONE  = 2'd0;
    localparam logic [1:0] MARK_SET   = 2'd1;
    localparam logic [1:0] MARK_CLEAR = 2'd2;

    localparam logic [1:0] UPLOAD_NONE     = 2'd0;
    localparam logic [1:0] UPLOAD_WORKING  = 2'd1;
    localparam logic [1:0] UPLOAD_ORIGINAL = 2'd2;

    localparam logic [1:0] WALK_MARK   = 2'd0;
    localparam logic [1:0] WALK_DOWN   = 2'd1;
    localparam logic [1:0] WALK_VANISH = 2'd2;
    localparam logic [1:0] WALK_UP     = 2'd3;

    localparam logic [COLOR_W-1:0] SEMI_MASK  = 16'h8000;
    localparam logic [COLOR_W-1:0] RED_MASK   = 16'h001F;
    localparam logic [COLOR_W-1:0] GREEN_MASK = 16'h03E0;
    localparam logic [COLOR_W-1:0] BLUE_MASK  = 16'h7C00;
    localparam logic [COLOR_W-1:0] RED_STEP   = 16'd1;
    localparam logic [COLOR_W-1:0] GREEN_STEP = 16'd32;
    localparam logic [COLOR_W-1:0] BLUE_STEP  = 16'd1024;

    localparam int FADE_FIRST  = 8;
    localparam int RISE_FIRST  = 1;

    localparam logic [DELAY_W-1:0] DELAY_ONE  = 3'd1;
    localparam logic [DELAY_W-1:0] DELAY_FIVE = 3'd5;

    localparam logic [MODE_W-1:0] RENDER_FADE = 8'd1;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq_state;
        logic               apply_render_mode;
        logic [MODE_W-1:0]  render_mode_value;
        logic               apply_anim_flags;
        logic               semi_trans_value;
        logic               blending_value;
        logic [1:0]         mark_change;
        logic [1:0]         upload_request;
        logic [DELAY_W-1:0] next_delay;
        logic               effect_dead;
        logic               flicker_start;
        logic [COLOR_W-1:0] entry_out;
    } pfs_result_t;

endpackage

`default_nettype wire

### sv/pfs_if.sv
`default_nettype none

interface pfs_cfg_if;
    import pfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pfs_req_if;
    import pfs_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  entry_index;
    logic [COLOR_W-1:0]  entry_value;
    logic                target_gone;
    logic                death_reset;

    modport source (output valid, output action, output entry_index, output entry_value,
                    output target_gone, output death_reset, input ready);
    modport sink   (input valid, input action, input entry_index, input entry_value,
                    input target_gone, input death_reset, output ready);
endinterface

interface pfs_rsp_if;
    import pfs_pkg::*;
    logic               valid;
    logic               ready;
    logic [SEQ_W-1:0]   seq_state;
    logic               apply_render_mode;
    logic [MODE_W-1:0]  render_mode_value;
    logic               apply_anim_flags;
    logic               semi_trans_value;
    logic               blending_value;
    logic [1:0]         mark_change;
    logic [1:0]         upload_request;
    logic [DELAY_W-1:0] next_delay;
    logic               effect_dead;
    logic               flicker_start;
    logic [COLOR_W-1:0] entry_out;

    modport source (output valid, output seq_state, output apply_render_mode,
                    output render_mode_value, output apply_anim_flags,
                    output semi_trans_value, output blending_value, output mark_change,
                    output upload_request, output next_delay, output effect_dead,
                    output flicker_start, output entry_out, input ready);
    modport sink   (input valid, input seq_state, input apply_render_mode,
                    input render_mode_value, input apply_anim_flags,
                    input semi_trans_value, input blending_value, input mark_change,
                    input upload_request, input next_delay, input effect_dead,
                    input flicker_start, input entry_out, output ready);
endinterface

`default_nettype wire

### sv/pfs_ram.sv
`default_nettype none

module pfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/pfs_step_unit.sv
`default_nettype none

module pfs_step_unit import pfs_pkg::*; (
    input  wire logic [1:0]         mode,
    input  wire logic [COLOR_W-1:0] cur,
    input  wire logic [COLOR_W-1:0] orig,
    output logic      [COLOR_W-1:0] nxt,
    output logic                    moved
);

    logic [COLOR_W-1:0] v;
    logic               m;

    always_comb
    begin
        v = cur;
        m = 1'b0;
        case (mode)
            WALK_MARK:
            begin
                v = cur | SEMI_MASK;
            end
            WALK_VANISH:
            begin
                v = cur & SEMI_MASK;
            end
            WALK_DOWN:
            begin
                if ((v & RED_MASK) != '0)
                begin
                    m = 1'b1;
                    v = v - RED_STEP;
                end
                if ((v & GREEN_MASK) != '0)
                begin
                    m = 1'b1;
                    v = v - GREEN_STEP;
                end
                if ((v & BLUE_MASK) != '0)
                begin
                    m = 1'b1;
                    v = v - BLUE_STEP;
                end
                if (v == SEMI_MASK)
                begin
                    v = '0;
                end
            end
            WALK_UP:
            begin
                if (((v ^ orig) & RED_MASK) != '0)
                begin
                    m = 1'b1;
                    v = v + RED_STEP;
                end
                if (((v ^ orig) & GREEN_MASK) != '0)
                begin
                    m = 1'b1;
                    v = v + GREEN_STEP;
                end
                if (((v ^ orig) & BLUE_MASK) != '0)
                begin
                    m = 1'b1;
                    v = v + BLUE_STEP;
                end
            end
            default:
            begin
                v = cur;
            end
        endcase
        nxt   = v;
        moved = m;
    end

endmodule

`default_nettype wire

### sv/palette_fade_sequencer_core.sv
`default_nettype none

// Channel | Direction | Beat contents
// cfg     | in        | register index, write data
// req     | in        | action, entry_index, entry_value, target_gone, death_reset
// rsp     | out       | sequencer state and the requests of one item
//
// Loads and commands pass from accept through decode and finish into the output register;
// reads add a RAM read state; an update that walks the palette adds a walk, which runs one
// entry per cycle through a single step unit and the read port of each palette RAM.
// Reset clears the control state only; palette contents are undefined until loaded.
// A new beat is accepted while a result waits; a finished result holds while rsp stalls.

module palette_fade_sequencer_core import pfs_pkg::*; #(
    parameter int PALETTE_ENTRIES = PFS_ENTRIES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pfs_cfg_if.sink    cfg,
    pfs_req_if.sink    req,
    pfs_rsp_if.source  rsp
);

    localparam int IW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(PALETTE_ENTRIES + 1);
    localparam logic [DEPTH_W-1:0] ENTRIES_D = DEPTH_W'(PALETTE_ENTRIES);

    localparam logic [2:0] C_IDLE   = 3'd0;
    localparam logic [2:0] C_DECODE = 3'd1;
    localparam logic [2:0] C_WALK   = 3'd2;
    localparam logic [2:0] C_READ   = 3'd3;
    localparam logic [2:0] C_FIN    = 3'd4;

    logic [2:0]         ctl_reg, ctl_next;
    logic [SEQ_W-1:0]   fsm_reg, fsm_next;
    logic               vanish_reg, vanish_next;
    logic               dead_reg, dead_next;
    logic               moved_reg;
    logic               iss_active_reg;
    logic [CW-1:0]      iss_cnt_reg;
    logic               p_valid_reg;
    logic [IW-1:0]      p_idx_reg;
    logic               out_valid_reg;
    pfs_result_t        pend_reg, pend_next, out_reg;

    logic [DEPTH_W-1:0] depth_reg;
    logic               semi_reg, blend_reg;
    logic [MODE_W-1:0]  render_reg;

    logic [ACTION_W-1:0] it_action_reg;
    logic [INDEX_W-1:0]  it_index_reg;
    logic [COLOR_W-1:0]  it_value_reg;
    logic                it_gone_reg, it_death_reg;

    logic [CW-1:0]      d_use, walk_start;
    logic [1:0]         walk_mode;
    logic               walk_seq, walk_go, walk_done, commit, in_range, out_free, accept;

    logic               w_we, o_we;
    logic [IW-1:0]      w_waddr, rd_addr;
    logic [COLOR_W-1:0] w_wdata, w_rdata, o_rdata, step_value;
    logic               step_moved;

    assign cfg.ready = 1'b1;
    assign req.ready = (ctl_reg == C_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign d_use    = (depth_reg > ENTRIES_D) ? CW'(PALETTE_ENTRIES) : depth_reg[CW-1:0];
    assign in_range = ({1'b0, it_index_reg} < ENTRIES_D);

    always_comb
    begin
        walk_seq   = 1'b1;
        walk_mode  = WALK_MARK;
        walk_start = CW'(FADE_FIRST);
        case (fsm_reg)
            SEQ_MARK:     walk_mode = WALK_MARK;
            SEQ_FADE_OUT: walk_mode = WALK_DOWN;
            SEQ_VANISH:   walk_mode = WALK_VANISH;
            SEQ_FADE_IN:
            begin
                walk_mode  = WALK_UP;
                walk_start = CW'(RISE_FIRST);
            end
            default:      walk_seq = 1'b0;
        endcase
    end

    assign walk_go = (it_action_reg == ACT_UPDATE) && !dead_reg && !it_gone_reg
                     && walk_seq && (d_use > walk_start);
    assign walk_done = (ctl_reg == C_WALK) && !iss_active_reg && !p_valid_reg;
    assign commit    = ((ctl_reg == C_DECODE) && !walk_go) || walk_done;

    always_comb
    begin
        pend_next   = '0;
        fsm_next    = fsm_reg;
        vanish_next = vanish_reg;
        dead_next   = dead_reg;
        case (it_action_reg)
            ACT_UPDATE:
            begin
                if (!dead_reg)
                begin
                    if (it_death_reg || it_gone_reg)
                    begin
                        dead_next = 1'b1;
                    end
                    if (!it_gone_reg)
                    begin
                        case (fsm_reg)
                            SEQ_IDLE:
                            begin
                                pend_next.apply_render_mode = 1'b1;
                                pend_next.render_mode_value = RENDER_FADE;
                            end
                            SEQ_MARK:
                            begin
                                pend_next.mark_change       = MARK_SET;
                                pend_next.apply_anim_flags  = 1'b1;
                                pend_next.semi_trans_value  = 1'b1;
                                pend_next.apply_render_mode = 1'b1;
                                pend_next.render_mode_value = RENDER_FADE;
                                pend_next.next_delay        = DELAY_ONE;
                                fsm_next = vanish_reg ? SEQ_VANISH : SEQ_FADE_OUT;
                            end
                            SEQ_VANISH:
                            begin
                                pend_next.upload_request = UPLOAD_WORKING;
                                pend_next.next_delay     = DELAY_ONE;
                                vanish_next = 1'b0;
                                fsm_next    = SEQ_IDLE;
                            end
                            SEQ_FADE_OUT:
                            begin
                                if (moved_reg)
                                begin
                                    pend_next.upload_request = UPLOAD_WORKING;
                                    pend_next.next_delay     = DELAY_ONE;
                                end
                                else
                                begin
                                    fsm_next = SEQ_IDLE;
                                end
                            end
                            SEQ_FADE_IN:
                            begin
                                if (moved_reg)
                                begin
                                    pend_next.upload_request    = UPLOAD_WORKING;
                                    pend_next.apply_render_mode = 1'b1;
                                    pend_next.render_mode_value = RENDER_FADE;
                                    pend_next.next_delay        = DELAY_FIVE;
                                end
                                else
                                begin
                                    fsm_next = SEQ_RESTORE;
                                end
                            end
                            SEQ_RESTORE:
                            begin
                                pend_next.upload_request    = UPLOAD_ORIGINAL;
                                pend_next.apply_anim_flags  = 1'b1;
                                pend_next.semi_trans_value  = semi_reg;
                                pend_next.blending_value    = blend_reg;
                                pend_next.apply_render_mode = 1'b1;
                                pend_next.render_mode_value = render_reg;
                                pend_next.mark_change       = MARK_CLEAR;
                                pend_next.next_delay        = DELAY_ONE;
                                pend_next.flicker_start     = 1'b1;
                                fsm_next = SEQ_DEAD;
                            end
                            SEQ_DEAD:
                            begin
                                dead_next = 1'b1;
                            end
                            default:
                            begin
                                fsm_next = fsm_reg;
                            end
                        endcase
                    end
                end
            end
            ACT_VANISH:
            begin
                vanish_next          = 1'b1;
                pend_next.next_delay = DELAY_ONE;
                fsm_next             = SEQ_MARK;
            end
            ACT_FADE_OUT:
            begin
                pend_next.next_delay = DELAY_ONE;
                fsm_next             = SEQ_MARK;
            end
            ACT_FADE_IN:
            begin
                fsm_next = SEQ_FADE_IN;
            end
            ACT_RESTORE:
            begin
                pend_next.next_delay = DELAY_ONE;
                fsm_next             = SEQ_RESTORE;
            end
            default:
            begin
                fsm_next = fsm_reg;
            end
        endcase
        pend_next.seq_state   = fsm_next;
        pend_next.effect_dead = dead_next;
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        case (ctl_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    ctl_next = C_DECODE;
                end
            end
            C_DECODE:
            begin
                if (walk_go)
                begin
                    ctl_next = C_WALK;
                end
                else if (it_action_reg == ACT_READ)
                begin
                    ctl_next = C_READ;
                end
                else
                begin
                    ctl_next = C_FIN;
                end
            end
            C_WALK:
            begin
                if (walk_done)
                begin
                    ctl_next = C_FIN;
                end
            end
            C_READ:
            begin
                ctl_next = C_FIN;
            end
            C_FIN:
            begin
                if (out_free)
                begin
                    ctl_next = C_IDLE;
                end
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase
    end

    assign rd_addr = (ctl_reg == C_WALK) ? iss_cnt_reg[IW-1:0] : it_index_reg[IW-1:0];
    assign o_we    = (ctl_reg == C_DECODE) && (it_action_reg == ACT_LOAD) && in_range;
    assign w_we    = o_we || ((ctl_reg == C_WALK) && p_valid_reg);
    assign w_waddr = (ctl_reg == C_WALK) ? p_idx_reg : it_index_reg[IW-1:0];
    assign w_wdata = (ctl_reg == C_WALK) ? step_value : it_value_reg;

    pfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_working (
        .clk     (clk),
        .wr_en   (w_we),
        .wr_addr (w_waddr),
        .wr_data (w_wdata),
        .rd_addr (rd_addr),
        .rd_data (w_rdata)
    );

    pfs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_original (
        .clk     (clk),
        .wr_en   (o_we),
        .wr_addr (it_index_reg[IW-1:0]),
        .wr_data (it_value_reg),
        .rd_addr (rd_addr),
        .rd_data (o_rdata)
    );

    pfs_step_unit u_step (
        .mode  (walk_mode),
        .cur   (w_rdata),
        .orig  (o_rdata),
        .nxt   (step_value),
        .moved (step_moved)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg        <= C_IDLE;
            fsm_reg        <= SEQ_IDLE;
            vanish_reg     <= 1'b0;
            dead_reg       <= 1'b0;
            moved_reg      <= 1'b0;
            iss_active_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            depth_reg      <= ENTRIES_D;
            semi_reg       <= 1'b0;
            blend_reg      <= 1'b0;
            render_reg     <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_DEPTH:       depth_reg  <= cfg.data;
                    REG_SEMI_TRANS:  semi_reg   <= cfg.data[0];
                    REG_BLENDING:    blend_reg  <= cfg.data[0];
                    REG_RENDER_MODE: render_reg <= cfg.data[MODE_W-1:0];
                    default:         depth_reg  <= depth_reg;
                endcase
            end
            if (commit)
            begin
                fsm_reg    <= fsm_next;
                vanish_reg <= vanish_next;
                dead_reg   <= dead_next;
            end
            if (accept)
            begin
                moved_reg <= 1'b0;
            end
            else if ((ctl_reg == C_WALK) && p_valid_reg && step_moved)
            begin
                moved_reg <= 1'b1;
            end
            if ((ctl_reg == C_DECODE) && walk_go)
            begin
                iss_active_reg <= 1'b1;
            end
            else if ((ctl_reg == C_WALK) && (iss_cnt_reg == d_use - CW'(1)))
            begin
                iss_active_reg <= 1'b0;
            end
            p_valid_reg <= (ctl_reg == C_WALK) && iss_active_reg;
            if ((ctl_reg == C_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            it_action_reg <= req.action;
            it_index_reg  <= req.entry_index;
            it_value_reg  <= req.entry_value;
            it_gone_reg   <= req.target_gone;
            it_death_reg  <= req.death_reset;
        end
        if ((ctl_reg == C_DECODE) && walk_go)
        begin
            iss_cnt_reg <= walk_start;
        end
        else if (ctl_reg == C_WALK)
        begin
            iss_cnt_reg <= iss_cnt_reg + CW'(1);
        end
        p_idx_reg <= iss_cnt_reg[IW-1:0];
        if (commit)
        begin
            pend_reg <= pend_next;
        end
        else if (ctl_reg == C_READ)
        begin
            pend_reg.entry_out <= in_range ? w_rdata : '0;
        end
        if ((ctl_reg == C_FIN) && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.seq_state         = out_reg.seq_state;
    assign rsp.apply_render_mode = out_reg.apply_render_mode;
    assign rsp.render_mode_value = out_reg.render_mode_value;
    assign rsp.apply_anim_flags  = out_reg.apply_anim_flags;
    assign rsp.semi_trans_value  = out_reg.semi_trans_value;
    assign rsp.blending_value    = out_reg.blending_value;
    assign rsp.mark_change       = out_reg.mark_change;
    assign rsp.upload_request    = out_reg.upload_request;
    assign rsp.next_delay        = out_reg.next_delay;
    assign rsp.effect_dead       = out_reg.effect_dead;
    assign rsp.flicker_start     = out_reg.flicker_start;
    assign rsp.entry_out         = out_reg.entry_out;

    // The walk never issues a read beyond the palette depth in use.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_reg == C_WALK && iss_active_reg) |-> (iss_cnt_reg < d_use))
        else $error("walk issued an entry beyond the depth in use");

    a_walk_write: assert property (@(posedge clk) disable iff (!rst_n)
        (w_we && ctl_reg != C_DECODE) |-> (ctl_reg == C_WALK && p_valid_reg))
        else $error("working palette written outside a walk beat");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (ctl_reg == C_DECODE))
        else $error("accepted beat did not move to decode");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg <= SEQ_DEAD)
        else $error("sequencer state out of range");

endmodule

`default_nettype wire
